// ===== src/binned_mean_histogram_unit_macros.svh =====
// Assertion helpers shared by the histogram RTL.
// Each check is clocked on i_clk and switched off while i_rst_n is low.
`ifndef BINNED_MEAN_HISTOGRAM_UNIT_MACROS_SVH
`define BINNED_MEAN_HISTOGRAM_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BMH_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("binned mean histogram check failed");
`define BMH_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("binned mean histogram check failed");
`else
`define BMH_ASSERT(lbl, expr)
`define BMH_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ===== src/bmh_pkg.sv =====
package bmh_pkg;

    localparam int COUNT_WIDTH  = 16;
    localparam int SAMPLE_WIDTH = 32;
    localparam int SUM_WIDTH    = 48;
    localparam int INDEX_WIDTH  = 12;
    localparam int BW_WIDTH     = 31;
    localparam int ADDR_W       = 4;
    localparam int REG_IDX_W    = 2;
    localparam int DATA_W       = 32;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam int DIV_STEPS = SUM_WIDTH;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic signed [SAMPLE_WIDTH-1:0] RANGE_START_RST = '0;
    localparam logic [BW_WIDTH-1:0]            BIN_WIDTH_RST   = BW_WIDTH'(65536);
    localparam logic [INDEX_WIDTH-1:0]         BAND_COUNT_RST  = INDEX_WIDTH'(9);
    localparam logic [COUNT_WIDTH-1:0]         TALLY_MAX       = {COUNT_WIDTH{1'b1}};
    localparam logic signed [SAMPLE_WIDTH-1:0] LIMIT_MAX       =
        {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

    typedef enum logic [REG_IDX_W-1:0] {
        REG_RANGE_START = 2'd0,
        REG_BIN_WIDTH   = 2'd1,
        REG_BAND_COUNT  = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_HOLD
    } t_back_state;

    typedef struct packed {
        logic                   en;
        logic [REG_IDX_W-1:0]   idx;
        logic [DATA_W-1:0]      data;
    } t_cfg_wr;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] range_start;
        logic [BW_WIDTH-1:0]            bin_width;
        logic [INDEX_WIDTH-1:0]         band_count;
    } t_cfg_regs;

    // One closed bar waiting for its division.
    typedef struct packed {
        logic signed [SUM_WIDTH-1:0] sum;
        logic [COUNT_WIDTH-1:0]      tally;
        logic [INDEX_WIDTH-1:0]      index;
        logic                        last;
    } t_bmh_req;

    // Clamp a 33-bit sum of a limit and a nonnegative width to the Q16.16 range.
    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_limit(
        input logic [SAMPLE_WIDTH:0] s
    );
        logic signed [SAMPLE_WIDTH-1:0] res;
        if (s[SAMPLE_WIDTH] != s[SAMPLE_WIDTH-1]) begin
            res = LIMIT_MAX;
        end else begin
            res = s[SAMPLE_WIDTH-1:0];
        end
        return res;
    endfunction

endpackage

// ===== src/bmh_channels_if.sv =====
interface bmh_point_if;
    import bmh_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] x_value;
    logic signed [SAMPLE_WIDTH-1:0] y_value;
    logic                           last_point;

    modport source (output valid, output x_value, output y_value, output last_point,
                    input ready);
    modport sink   (input valid, input x_value, input y_value, input last_point,
                    output ready);
endinterface

interface bmh_bar_if;
    import bmh_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] bar_mean;
    logic [INDEX_WIDTH-1:0]         bar_index;
    logic [COUNT_WIDTH-1:0]         bar_points;
    logic                           run_last;

    modport source (output valid, output bar_mean, output bar_index, output bar_points,
                    output run_last, input ready);
    modport sink   (input valid, input bar_mean, input bar_index, input bar_points,
                    input run_last, output ready);
endinterface

// ===== src/bmh_queue.sv =====
`include "binned_mean_histogram_unit_macros.svh"

module bmh_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push0,
    input  logic              i_push1,
    input  bmh_pkg::t_bmh_req i_req0,
    input  bmh_pkg::t_bmh_req i_req1,
    input  logic              i_pop,
    output bmh_pkg::t_bmh_req o_head,
    output logic              o_valid,
    output logic              o_room
);
    import bmh_pkg::*;

    t_bmh_req            r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QPTR_W:0]     r_count;
    logic [QPTR_W:0]     n_count;
    logic [QPTR_W-1:0]   wr_next;
    logic [QPTR_W:0]     push_cnt;

    assign wr_next  = r_wr + QPTR_W'(1);
    assign push_cnt = (QPTR_W+1)'(i_push0) + (QPTR_W+1)'(i_push1);
    assign n_count  = r_count + push_cnt - (QPTR_W+1)'(i_pop);

    // Room for two requests, since one point can close a bar and flush the next.
    assign o_room  = (r_count <= (QPTR_W+1)'(QDEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr] <= i_req0;
        end
        if (i_push1) begin
            r_mem[wr_next] <= i_req1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + push_cnt[QPTR_W-1:0];
            r_count <= n_count;
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
        end
    end

    `BMH_ASSERT(a_q_bound, r_count <= (QPTR_W+1)'(QDEPTH))
    `BMH_ASSERT(a_q_pair, !i_push1 || i_push0)
    `BMH_ASSERT(a_q_pop_nonempty, !i_pop || o_valid)
endmodule

// ===== src/bmh_front.sv =====
`include "binned_mean_histogram_unit_macros.svh"

module bmh_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bmh_point_if.sink          i_point,
    input  bmh_pkg::t_cfg_wr   i_cfg_wr,
    output bmh_pkg::t_cfg_regs o_cfg,
    input  logic               i_q_room,
    output logic               o_push0,
    output logic               o_push1,
    output bmh_pkg::t_bmh_req  o_req0,
    output bmh_pkg::t_bmh_req  o_req1
);
    import bmh_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] r_range_start, n_range_start;
    logic [BW_WIDTH-1:0]            r_bin_width, n_bin_width;
    logic [INDEX_WIDTH-1:0]         r_band_count, n_band_count;

    logic signed [SAMPLE_WIDTH-1:0] r_bar_limit, n_bar_limit;
    logic signed [SUM_WIDTH-1:0]    r_sum, n_sum;
    logic [COUNT_WIDTH-1:0]         r_tally, n_tally;
    logic [INDEX_WIDTH-1:0]         r_bars, n_bars;
    logic                           r_stopped, n_stopped;

    logic                           accept;
    logic                           cfg_hit;
    logic                           active;
    logic                           close;
    logic                           stop_now;
    logic                           count_it;
    logic                           flush;
    logic [INDEX_WIDTH-1:0]         bands;
    logic [INDEX_WIDTH-1:0]         bars_inc;
    logic signed [SAMPLE_WIDTH-1:0] step_limit;
    logic signed [SAMPLE_WIDTH-1:0] base_limit;
    logic signed [SUM_WIDTH-1:0]    sum_mid, sum_new;
    logic [COUNT_WIDTH-1:0]         tally_mid, tally_new;
    logic                           stopped_mid;
    logic [INDEX_WIDTH-1:0]         bars_new;
    logic signed [SUM_WIDTH-1:0]    y_ext;
    t_bmh_req                       req_close, req_flush;

    assign i_point.ready = i_q_room;
    assign accept        = i_point.valid && i_q_room;

    assign o_cfg.range_start = r_range_start;
    assign o_cfg.bin_width   = r_bin_width;
    assign o_cfg.band_count  = r_band_count;

    // Register writes; any write to a real register restarts the run.
    always_comb begin
        n_range_start = r_range_start;
        n_bin_width   = r_bin_width;
        n_band_count  = r_band_count;
        cfg_hit       = 1'b0;
        if (i_cfg_wr.en) begin
            case (i_cfg_wr.idx)
                REG_RANGE_START: begin
                    n_range_start = i_cfg_wr.data[SAMPLE_WIDTH-1:0];
                    cfg_hit       = 1'b1;
                end
                REG_BIN_WIDTH: begin
                    n_bin_width = i_cfg_wr.data[BW_WIDTH-1:0];
                    cfg_hit     = 1'b1;
                end
                REG_BAND_COUNT: begin
                    n_band_count = i_cfg_wr.data[INDEX_WIDTH-1:0];
                    cfg_hit      = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    assign base_limit = sat_limit({n_range_start[SAMPLE_WIDTH-1], n_range_start}
                                  + {2'b00, n_bin_width});
    assign step_limit = sat_limit({r_bar_limit[SAMPLE_WIDTH-1], r_bar_limit}
                                  + {2'b00, r_bin_width});

    assign bands    = (r_band_count == '0) ? INDEX_WIDTH'(1) : r_band_count;
    assign bars_inc = r_bars + INDEX_WIDTH'(1);
    assign y_ext    = {{(SUM_WIDTH-SAMPLE_WIDTH){i_point.y_value[SAMPLE_WIDTH-1]}},
                       i_point.y_value};

    assign active      = !r_stopped && (i_point.x_value >= r_range_start);
    assign close       = active && (i_point.x_value >= r_bar_limit);
    assign stop_now    = close && (bars_inc >= bands);
    assign stopped_mid = r_stopped || stop_now;
    assign sum_mid     = close ? '0 : r_sum;
    assign tally_mid   = close ? '0 : r_tally;
    assign bars_new    = close ? bars_inc : r_bars;

    // The point that closes a bar opens the next one unless it ends the run; a full bar takes no more.
    assign count_it  = active && !stopped_mid && (tally_mid < TALLY_MAX);
    assign sum_new   = count_it ? (sum_mid + y_ext) : sum_mid;
    assign tally_new = count_it ? (tally_mid + COUNT_WIDTH'(1)) : tally_mid;
    assign flush     = i_point.last_point && !stopped_mid && (tally_new != '0);

    always_comb begin
        req_close.sum   = r_sum;
        req_close.tally = r_tally;
        req_close.index = r_bars;
        req_close.last  = !flush;
        req_flush.sum   = sum_new;
        req_flush.tally = tally_new;
        req_flush.index = bars_new;
        req_flush.last  = 1'b1;
    end

    assign o_push0 = accept && (close || flush);
    assign o_push1 = accept && close && flush;
    assign o_req0  = close ? req_close : req_flush;
    assign o_req1  = req_flush;

    always_comb begin
        n_bar_limit = r_bar_limit;
        n_sum       = r_sum;
        n_tally     = r_tally;
        n_bars      = r_bars;
        n_stopped   = r_stopped;
        if (accept) begin
            n_sum     = sum_new;
            n_tally   = tally_new;
            n_bars    = bars_new;
            n_stopped = stopped_mid;
            if (close && !stop_now) begin
                n_bar_limit = step_limit;
            end
        end
        if ((accept && i_point.last_point) || cfg_hit) begin
            n_bar_limit = base_limit;
            n_sum       = '0;
            n_tally     = '0;
            n_bars      = '0;
            n_stopped   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_start <= RANGE_START_RST;
            r_bin_width   <= BIN_WIDTH_RST;
            r_band_count  <= BAND_COUNT_RST;
            r_bar_limit   <= sat_limit({RANGE_START_RST[SAMPLE_WIDTH-1], RANGE_START_RST}
                                       + {2'b00, BIN_WIDTH_RST});
            r_sum         <= '0;
            r_tally       <= '0;
            r_bars        <= '0;
            r_stopped     <= 1'b0;
        end else begin
            r_range_start <= n_range_start;
            r_bin_width   <= n_bin_width;
            r_band_count  <= n_band_count;
            r_bar_limit   <= n_bar_limit;
            r_sum         <= n_sum;
            r_tally       <= n_tally;
            r_bars        <= n_bars;
            r_stopped     <= n_stopped;
        end
    end

    `BMH_ASSERT(a_fr_stop_count, !r_stopped || (r_bars >= bands))
    `BMH_ASSERT(a_fr_flush_pair, !o_push1 || (o_req0.last == 1'b0))
endmodule

// ===== src/bmh_back.sv =====
`include "binned_mean_histogram_unit_macros.svh"

module bmh_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  bmh_pkg::t_bmh_req i_req,
    output logic              o_pop,
    bmh_bar_if.source         o_bar
);
    import bmh_pkg::*;

    t_back_state               r_state, n_state;
    logic [STEP_W-1:0]         r_step;
    logic [SUM_WIDTH-1:0]      r_quo;
    logic [COUNT_WIDTH-1:0]    r_rem;
    logic [COUNT_WIDTH-1:0]    r_tally;
    logic [INDEX_WIDTH-1:0]    r_index;
    logic                      r_neg;
    logic                      r_last;

    logic                      r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_mean;
    logic [INDEX_WIDTH-1:0]    r_out_index;
    logic [COUNT_WIDTH-1:0]    r_out_points;
    logic                      r_out_last;

    logic                      load_div;
    logic                      do_step;
    logic                      load_out;
    logic                      out_take;
    logic [COUNT_WIDTH:0]      shifted;
    logic                      fits;
    logic [COUNT_WIDTH:0]      diff;
    logic [SAMPLE_WIDTH-1:0]   quo_low;
    logic signed [SAMPLE_WIDTH-1:0] mean;

    assign out_take = r_out_valid && o_bar.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = BK_HOLD;
                end
            end
            BK_HOLD: begin
                if (!r_out_valid || o_bar.ready) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        load_div = 1'b0;
        do_step  = 1'b0;
        load_out = 1'b0;
        case (r_state)
            BK_IDLE: load_div = i_q_valid;
            BK_DIV:  do_step  = 1'b1;
            BK_HOLD: load_out = !r_out_valid || o_bar.ready;
            default: load_div = 1'b0;
        endcase
    end

    assign o_pop = load_div;

    // Restoring division, one quotient bit per cycle, on the magnitude of the sum.
    assign shifted = {r_rem, r_quo[SUM_WIDTH-1]};
    assign fits    = (shifted >= {1'b0, r_tally});
    assign diff    = shifted - {1'b0, r_tally};

    assign quo_low = r_quo[SAMPLE_WIDTH-1:0];
    always_comb begin
        if (r_tally == '0) begin
            mean = '0;
        end else if (r_neg) begin
            mean = ~quo_low + SAMPLE_WIDTH'(1);
        end else begin
            mean = quo_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_div) begin
            r_neg   <= i_req.sum[SUM_WIDTH-1];
            r_quo   <= i_req.sum[SUM_WIDTH-1] ? (~i_req.sum + SUM_WIDTH'(1)) : i_req.sum;
            r_rem   <= '0;
            r_tally <= i_req.tally;
            r_index <= i_req.index;
            r_last  <= i_req.last;
        end else if (do_step) begin
            r_rem <= fits ? diff[COUNT_WIDTH-1:0] : shifted[COUNT_WIDTH-1:0];
            r_quo <= {r_quo[SUM_WIDTH-2:0], fits};
        end
        if (load_out) begin
            r_out_mean   <= mean;
            r_out_index  <= r_index;
            r_out_points <= r_tally;
            r_out_last   <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_div) begin
                r_step <= '0;
            end else if (do_step) begin
                r_step <= r_step + STEP_W'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_bar.valid      = r_out_valid;
    assign o_bar.bar_mean   = r_out_mean;
    assign o_bar.bar_index  = r_out_index;
    assign o_bar.bar_points = r_out_points;
    assign o_bar.run_last   = r_out_last;

    `BMH_ASSERT(a_bk_step_range, (r_state != BK_DIV) || (r_step < STEP_W'(DIV_STEPS)))
    `BMH_ASSERT_NEXT(a_bk_hold_loads, (r_state == BK_HOLD) && !r_out_valid, r_out_valid)
    `BMH_ASSERT_NEXT(a_bk_pop_starts, o_pop, (r_state == BK_DIV) && (r_step == '0))
endmodule

// ===== src/binned_mean_histogram_unit.sv =====
// Binned mean histogram over a stream of Q16.16 (x, y) points sorted by x.
// Points arrive on i_point (valid/ready); one request is accepted when both
// are high. Closed bars leave on o_bar as (mean, index, points, run_last).
// Registers range_start, bin_width and band_count sit on an APB-style port
// at byte addresses 0, 4 and 8; writing one restarts the run.
// The front end takes one point per cycle as long as the request queue has
// room for two entries, so points that close no bar stream at full rate.
// For each closed bar the back end pops the queue, runs a one-bit-per-cycle
// restoring divider on the 48-bit sum, and then loads the output register.
// A point that closes a bar queues it for the back end; a last point may
// queue two bars, and the second is divided after the first.
// When o_bar is stalled the finished bar waits in the output register, the
// divider holds its next result, and the front keeps taking points until
// the four-entry queue is nearly full.
// Synchronous reset (i_rst_n low) restores register defaults, empties the
// queue and clears the run; no clearing pass is needed.
module binned_mean_histogram_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bmh_point_if.sink                    i_point,
    bmh_bar_if.source                    o_bar,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bmh_pkg::ADDR_W-1:0]   paddr,
    input  logic [bmh_pkg::DATA_W-1:0]   pwdata,
    output logic [bmh_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import bmh_pkg::*;

    t_cfg_wr   cfg_wr;
    t_cfg_regs cfg;
    logic      q_room;
    logic      q_valid;
    logic      push0;
    logic      push1;
    logic      pop;
    t_bmh_req  req0;
    t_bmh_req  req1;
    t_bmh_req  head;

    // Zero-wait-state port; a write lands in the access phase.
    assign pready      = 1'b1;
    assign cfg_wr.en   = psel && penable && pwrite && pready;
    assign cfg_wr.idx  = paddr[ADDR_W-1:2];
    assign cfg_wr.data = pwdata;

    always_comb begin
        case (paddr[ADDR_W-1:2])
            REG_RANGE_START: prdata = cfg.range_start;
            REG_BIN_WIDTH:   prdata = {{(DATA_W-BW_WIDTH){1'b0}}, cfg.bin_width};
            REG_BAND_COUNT:  prdata = {{(DATA_W-INDEX_WIDTH){1'b0}}, cfg.band_count};
            default:         prdata = '0;
        endcase
    end

    // The front end tracks the open bar and hands each closed one to the queue.
    bmh_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_point  (i_point),
        .i_cfg_wr (cfg_wr),
        .o_cfg    (cfg),
        .i_q_room (q_room),
        .o_push0  (push0),
        .o_push1  (push1),
        .o_req0   (req0),
        .o_req1   (req1)
    );

    bmh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (push0),
        .i_push1 (push1),
        .i_req0  (req0),
        .i_req1  (req1),
        .i_pop   (pop),
        .o_head  (head),
        .o_valid (q_valid),
        .o_room  (q_room)
    );

    // The back end divides each bar's sum by its count and drives the output.
    bmh_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_req     (head),
        .o_pop     (pop),
        .o_bar     (o_bar)
    );
endmodule
